// ===== hdl/rbls_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Row bitmap line store package
// Shared constants and types for the row bitmap line store.
// ---------------------------------------------------------------------------
package rbls_pkg;

	localparam int MAX_ROWS  = 32;
	localparam int ROW_W     = 64;
	localparam int IDX_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CFG_W     = 6;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RST   = 6'd63;
	localparam logic [CFG_W-1:0] ACTIVE_ROWS_RST = 6'd32;

	localparam logic REG_ROW_WIDTH   = 1'b0;
	localparam logic REG_ACTIVE_ROWS = 1'b1;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_INSERT  = 3'd1,
		OP_REPLACE = 3'd2,
		OP_DELETE  = 3'd3,
		OP_READ    = 3'd4,
		OP_GET     = 3'd5,
		OP_SET     = 3'd6,
		OP_CLEAR   = 3'd7
	} op_t;

endpackage
`default_nettype wire

// ===== hdl/rbls_req_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Row bitmap line store request channel
// Valid/ready channel that carries one operation per transaction.
// ---------------------------------------------------------------------------
interface rbls_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic signed [7:0] row_index;
	logic signed [7:0] column_index;
	logic [63:0]       data_value;

	modport source (output valid, output opcode, output row_index, output column_index,
		output data_value, input ready);
	modport sink (input valid, input opcode, input row_index, input column_index,
		input data_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/rbls_rsp_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Row bitmap line store response channel
// Valid/ready channel that carries one result per transaction.
// ---------------------------------------------------------------------------
interface rbls_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] row_out;
	logic        bit_out;
	logic        index_error;

	modport source (output valid, output row_out, output bit_out, output index_error,
		input ready);
	modport sink (input valid, input row_out, input bit_out, input index_error,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/row_bitmap_line_store.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Row bitmap line store
// Bitmap of 64-bit rows held in a synchronous memory, with row shifting,
// row access and pixel access operations.
// ---------------------------------------------------------------------------
// Replace, clear, out-of-range ops, insert at row H and delete of the bottom row
// go straight to the result state; read, get and set pixel wait for one memory
// read; other pushes and inserts at row y and other deletes of row y walk the
// memory, one row moved per cycle. A new transaction is accepted only after the
// result has moved to the output register; a waiting result holds it off.
// Reset clears the row valid bits at once, so all rows read as zero.
// ---------------------------------------------------------------------------
module row_bitmap_line_store (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	rbls_req_if.sink                                req,
	rbls_rsp_if.source                              rsp,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rbls_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [rbls_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [rbls_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDWAIT,
		S_SHIFT,
		S_INSFIN,
		S_DELFIN,
		S_DONE
	} state_t;

	localparam int IW = rbls_pkg::IDX_W;
	localparam int RW = rbls_pkg::ROW_W;

	state_t state_q;

	logic [rbls_pkg::CFG_W-1:0] row_width_q;
	logic [rbls_pkg::CFG_W-1:0] active_rows_q;

	rbls_pkg::op_t op_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] h_last_q;
	logic [RW-1:0] val_q;
	logic [5:0]    bitpos_q;

	logic [RW-1:0] res_row_q;
	logic          res_bit_q;
	logic          res_err_q;

	logic          out_valid_q;
	logic [RW-1:0] out_row_q;
	logic          out_bit_q;
	logic          out_err_q;

	logic [RW-1:0]       mem [rbls_pkg::MAX_ROWS];
	logic [rbls_pkg::MAX_ROWS-1:0] vld_q;
	logic [RW-1:0]       rdata_s1;
	logic                rvld_s1;
	logic                rd_pend_s1;
	logic [IW-1:0]       rd_addr_s1;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [RW-1:0] mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic          mem_clr;

	rbls_pkg::op_t op_in;
	logic          accept;
	logic [8:0]    ar9;
	logic [8:0]    max9;
	logic [8:0]    hgt9;
	logic [8:0]    hl9;
	logic [8:0]    y9;
	logic [8:0]    ins_y9;
	logic          y_neg;
	logic          ins_neg;
	logic          y_lt_h;
	logic          y_is_last;
	logic          ins_bad;
	logic          ins_at_end;
	logic          x_in;
	logic          pix_ok;
	logic [5:0]    bitpos_in;
	logic [IW-1:0] idx_in;
	logic [IW-1:0] ins_idx_in;
	logic [IW-1:0] h_last_in;
	logic [RW-1:0] rdat;
	logic [RW-1:0] pix_mask;
	logic [RW-1:0] set_word;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == rbls_pkg::REG_ACTIVE_ROWS)
		? {{(rbls_pkg::APB_DATA_W-rbls_pkg::CFG_W){1'b0}}, active_rows_q}
		: {{(rbls_pkg::APB_DATA_W-rbls_pkg::CFG_W){1'b0}}, row_width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= rbls_pkg::ROW_WIDTH_RST;
			active_rows_q <= rbls_pkg::ACTIVE_ROWS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == rbls_pkg::REG_ACTIVE_ROWS) begin
				active_rows_q <= pwdata[rbls_pkg::CFG_W-1:0];
			end else begin
				row_width_q <= pwdata[rbls_pkg::CFG_W-1:0];
			end
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign op_in     = rbls_pkg::op_t'(req.opcode);

	assign ar9       = {3'b000, active_rows_q};
	assign max9      = 9'(rbls_pkg::MAX_ROWS);
	assign hgt9      = (ar9 > max9) ? max9 : ar9;
	assign hl9       = hgt9 - 9'd1;
	assign y9        = {2'b00, req.row_index[6:0]};
	assign y_neg     = req.row_index[7];
	assign y_lt_h    = !y_neg && (y9 < hgt9);
	assign y_is_last = (y9 == hl9);
	assign ins_neg   = (op_in == rbls_pkg::OP_PUSH) ? 1'b0 : y_neg;
	assign ins_y9    = (op_in == rbls_pkg::OP_PUSH) ? 9'd0 : y9;
	assign ins_bad   = ins_neg || (ins_y9 > hgt9);
	assign ins_at_end = (ins_y9 == hgt9);
	assign x_in      = !req.column_index[7]
		&& ({1'b0, req.column_index[6:0]} < {2'b00, row_width_q});
	assign pix_ok    = x_in && y_lt_h;
	assign bitpos_in = row_width_q - req.column_index[5:0] - 6'd1;
	assign idx_in    = y9[IW-1:0];
	assign ins_idx_in = ins_y9[IW-1:0];
	assign h_last_in = hl9[IW-1:0];

	assign rdat      = rvld_s1 ? rdata_s1 : '0;
	assign pix_mask  = {{(RW-1){1'b0}}, 1'b1} << bitpos_q;
	assign set_word  = (val_q != '0) ? (rdat | pix_mask) : (rdat & ~pix_mask);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_clr   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_in)
						rbls_pkg::OP_PUSH, rbls_pkg::OP_INSERT: begin
							if (!ins_bad && !ins_at_end) begin
								mem_re    = 1'b1;
								mem_raddr = h_last_in;
							end
						end
						rbls_pkg::OP_REPLACE: begin
							if (y_lt_h) begin
								mem_we    = 1'b1;
								mem_waddr = idx_in;
								mem_wdata = req.data_value;
							end
						end
						rbls_pkg::OP_DELETE: begin
							if (y_lt_h) begin
								if (y_is_last) begin
									mem_we    = 1'b1;
									mem_waddr = h_last_in;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = idx_in + IW'(1);
								end
							end
						end
						rbls_pkg::OP_READ: begin
							if (y_lt_h) begin
								mem_re    = 1'b1;
								mem_raddr = idx_in;
							end
						end
						rbls_pkg::OP_GET, rbls_pkg::OP_SET: begin
							if (pix_ok) begin
								mem_re    = 1'b1;
								mem_raddr = idx_in;
							end
						end
						rbls_pkg::OP_CLEAR: begin
							mem_clr = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_RDWAIT: begin
				if (op_q == rbls_pkg::OP_SET) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = set_word;
				end
			end
			S_SHIFT: begin
				if (op_q == rbls_pkg::OP_DELETE) begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr_s1 - IW'(1);
					mem_wdata = rdat;
					if (rd_addr_s1 != h_last_q) begin
						mem_re    = 1'b1;
						mem_raddr = rd_addr_s1 + IW'(1);
					end
				end else begin
					if (rd_addr_s1 != h_last_q) begin
						mem_we    = 1'b1;
						mem_waddr = rd_addr_s1 + IW'(1);
						mem_wdata = rdat;
					end
					if (rd_addr_s1 != idx_q) begin
						mem_re    = 1'b1;
						mem_raddr = rd_addr_s1 - IW'(1);
					end
				end
			end
			S_INSFIN: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = val_q;
			end
			S_DELFIN: begin
				mem_we    = 1'b1;
				mem_waddr = h_last_q;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rvld_s1    <= 1'b0;
			rd_pend_s1 <= 1'b0;
			rd_addr_s1 <= '0;
		end else begin
			if (mem_clr) begin
				vld_q <= '0;
			end else if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			rd_pend_s1 <= mem_re;
			if (mem_re) begin
				rvld_s1    <= vld_q[mem_raddr];
				rd_addr_s1 <= mem_raddr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= rbls_pkg::OP_PUSH;
			idx_q       <= '0;
			h_last_q    <= '0;
			val_q       <= '0;
			bitpos_q    <= '0;
			res_row_q   <= '0;
			res_bit_q   <= 1'b0;
			res_err_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_bit_q   <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= op_in;
						idx_q     <= ins_idx_in;
						h_last_q  <= h_last_in;
						val_q     <= req.data_value;
						bitpos_q  <= bitpos_in;
						res_row_q <= '0;
						res_bit_q <= 1'b0;
						res_err_q <= 1'b0;
						state_q   <= S_DONE;
						unique case (op_in)
							rbls_pkg::OP_PUSH, rbls_pkg::OP_INSERT: begin
								if (ins_bad) begin
									res_err_q <= 1'b1;
								end else if (ins_at_end) begin
									res_row_q <= req.data_value;
								end else begin
									state_q <= S_SHIFT;
								end
							end
							rbls_pkg::OP_REPLACE: begin
								res_err_q <= !y_lt_h;
							end
							rbls_pkg::OP_DELETE: begin
								if (!y_lt_h) begin
									res_err_q <= 1'b1;
								end else if (!y_is_last) begin
									state_q <= S_SHIFT;
								end
							end
							rbls_pkg::OP_READ: begin
								if (!y_lt_h) begin
									res_err_q <= 1'b1;
								end else begin
									state_q <= S_RDWAIT;
								end
							end
							rbls_pkg::OP_GET: begin
								if (!pix_ok) begin
									res_bit_q <= 1'b1;
								end else begin
									state_q <= S_RDWAIT;
								end
							end
							rbls_pkg::OP_SET: begin
								if (pix_ok) begin
									state_q <= S_RDWAIT;
								end
							end
							rbls_pkg::OP_CLEAR: begin
							end
							default: begin
							end
						endcase
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
					if (op_q == rbls_pkg::OP_READ) begin
						res_row_q <= rdat;
					end else if (op_q == rbls_pkg::OP_GET) begin
						res_bit_q <= rdat[bitpos_q];
					end else begin
						res_bit_q <= 1'b1;
					end
				end
				S_SHIFT: begin
					if (op_q == rbls_pkg::OP_DELETE) begin
						if (rd_addr_s1 == h_last_q) begin
							state_q <= S_DELFIN;
						end
					end else begin
						if (rd_addr_s1 == h_last_q) begin
							res_row_q <= rdat;
						end
						if (rd_addr_s1 == idx_q) begin
							state_q <= S_INSFIN;
						end
					end
				end
				S_INSFIN: begin
					state_q <= S_DONE;
				end
				S_DELFIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_row_q   <= res_row_q;
						out_bit_q   <= res_bit_q;
						out_err_q   <= res_err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.row_out     = out_row_q;
	assign rsp.bit_out     = out_bit_q;
	assign rsp.index_error = out_err_q;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("memory read and write hit the same row in one cycle");

	a_shift_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> rd_pend_s1)
		else $error("row walk step without read data");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.bit_out && rsp.index_error))
		else $error("result reports both a pixel bit and an index error");

	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_clr |-> !mem_we && !mem_re)
		else $error("clear all overlaps a memory access");

endmodule
`default_nettype wire
